[hw/rtl/json_byte_tokenizer_top_macros.svh]
// Assertion macros for the JSON byte tokenizer.
// Used by json_byte_tokenizer_top.sv; no other dependencies.
`ifndef JSON_BYTE_TOKENIZER_TOP_MACROS_SVH
`define JSON_BYTE_TOKENIZER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define JBT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define JBT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Expression must never hold.
`define JBT_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/jbt_pkg.sv]
// Package for the JSON byte tokenizer: token codes, byte constants,
// literal tables and the token record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

    // Longest run the length counter tracks
    localparam int MAX_TOKEN_LEN = 4095;
    localparam int RUN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int LEN_W         = 12;
    localparam int LEN_CAP       = (1 << LEN_W) - 1;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_RBRACK = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_TRUE   = 4'd8;
    localparam logic [3:0] KIND_FALSE  = 4'd9;
    localparam logic [3:0] KIND_NULL   = 4'd10;
    localparam logic [3:0] KIND_END    = 4'd11;

    // Byte values
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Literal indexes: true, false, null
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Running token state
    typedef struct packed {
        logic [RUN_W-1:0] len;
        logic             quote;    // run opened with a quote
        logic [1:0]       bs;       // bit0 last byte backslash, bit1 one before
        logic [2:0]       lit;      // bit0 true, bit1 false, bit2 null possible
        logic             n_dot;
        logic             n_expo;
        logic             n_valid;
        logic             pend;     // valid number waiting for its end
        logic             ovf;
    } run_t;

    localparam run_t RUN_RESET = '{
        len: '0, quote: 1'b0, bs: 2'b00, lit: 3'b111,
        n_dot: 1'b0, n_expo: 1'b0, n_valid: 1'b1, pend: 1'b0, ovf: 1'b0
    };

    // One result token
    typedef struct packed {
        logic [3:0]       kind;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             last;
    } token_t;

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        case (k)
            LIT_TRUE:  lit_len = 3'd4;
            LIT_FALSE: lit_len = 3'd5;
            LIT_NULL:  lit_len = 3'd4;
            default:   lit_len = 3'd0;
        endcase
    endfunction

    function automatic logic [3:0] lit_kind(input logic [1:0] k);
        case (k)
            LIT_TRUE:  lit_kind = KIND_TRUE;
            LIT_FALSE: lit_kind = KIND_FALSE;
            default:   lit_kind = KIND_NULL;
        endcase
    endfunction

    // Expected byte of literal k at position pos
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
        logic [39:0] txt;
        case (k)
            LIT_TRUE:  txt = {"true", 8'h00};
            LIT_FALSE: txt = "false";
            LIT_NULL:  txt = {"null", 8'h00};
            default:   txt = '0;
        endcase
        case (pos)
            3'd0:    lit_char = txt[39:32];
            3'd1:    lit_char = txt[31:24];
            3'd2:    lit_char = txt[23:16];
            3'd3:    lit_char = txt[15:8];
            3'd4:    lit_char = txt[7:0];
            default: lit_char = 8'h00;
        endcase
    endfunction

    // Build a token, saturating the length to the port width
    function automatic token_t make_token(input logic [3:0] kind,
                                          input logic [RUN_W-1:0] len,
                                          input logic ovf);
        token_t t;
        t.kind = kind;
        t.last = 1'b0;
        if (32'(len) > 32'(LEN_CAP)) begin
            t.len = LEN_W'(LEN_CAP);
            t.ovf = 1'b1;
        end else begin
            t.len = LEN_W'(len);
            t.ovf = ovf;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/json_byte_tokenizer_top.sv]
// JSON byte tokenizer: one byte per request in, tokens (kind, length) out.
// Each token is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle; each byte yields up to two tokens, drained
// one per cycle while m_ready is high from a four-entry result queue, so
// s_ready drops when fewer than two queue slots are free.
// Reset (aresetn low, synchronous) clears the running token and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "json_byte_tokenizer_top_macros.svh"

module json_byte_tokenizer_top
    import jbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_token_kind,
    output logic [11:0]      m_token_length,
    output logic             m_length_overflow,
    output logic             m_last_of_run
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             run_reg, run_next;
    token_t           fifo_mem [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             acc, pop;
    logic [1:0]       n_push;
    token_t           slot0, slot1;

    // Byte classification
    logic             in_str, is_struct, is_ws, is_num_char, is_digit;
    logic [3:0]       struct_kind;

    // Byte processing on the (possibly flushed) run
    run_t             base, upd;
    logic             flushed, closes, lit_hit, pos_zero;
    logic [1:0]       hit_k;
    logic [RUN_W-1:0] pos;
    token_t           tok_a, tok_b;
    logic             a_v, b_v;

    assign acc = s_valid && s_ready;
    assign pop = m_valid && m_ready;

    // Queue status and head entry
    assign s_ready           = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign m_valid           = (cnt_reg != '0);
    assign m_token_kind      = fifo_mem[rd_ptr_reg].kind;
    assign m_token_length    = fifo_mem[rd_ptr_reg].len;
    assign m_length_overflow = fifo_mem[rd_ptr_reg].ovf;
    assign m_last_of_run     = fifo_mem[rd_ptr_reg].last;

    // Classify the incoming byte
    always_comb begin
        in_str   = (run_reg.len != '0) && run_reg.quote;
        is_digit = (s_text_byte >= CH_ZERO) && (s_text_byte <= CH_NINE);
        is_num_char = is_digit || (s_text_byte == CH_DOT) || (s_text_byte == CH_LOW_E)
                   || (s_text_byte == CH_UP_E) || (s_text_byte == CH_PLUS)
                   || (s_text_byte == CH_MINUS);
        is_struct   = 1'b1;
        struct_kind = KIND_LBRACE;
        case (s_text_byte)
            8'h7B:   struct_kind = KIND_LBRACE;
            8'h7D:   struct_kind = KIND_RBRACE;
            8'h5B:   struct_kind = KIND_LBRACK;
            8'h5D:   struct_kind = KIND_RBRACK;
            8'h3A:   struct_kind = KIND_COLON;
            8'h2C:   struct_kind = KIND_COMMA;
            default: is_struct = 1'b0;
        endcase
        case (s_text_byte)
            8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20: is_ws = 1'b1;
            default:                                   is_ws = 1'b0;
        endcase
    end

    // Extend the run with an ordinary byte
    always_comb begin
        flushed  = run_reg.pend && !is_num_char;
        base     = flushed ? RUN_RESET : run_reg;
        pos      = base.len;
        pos_zero = (pos == '0);
        upd      = base;

        upd.quote = pos_zero ? (s_text_byte == CH_QUOTE) : base.quote;
        for (int k = 0; k < 3; k++) begin
            upd.lit[k] = base.lit[k] && (pos < RUN_W'(lit_len(2'(k))))
                      && (lit_char(2'(k), pos[2:0]) == s_text_byte);
        end

        // Number scan
        if (base.n_valid) begin
            if ((s_text_byte == CH_LOW_E) || (s_text_byte == CH_UP_E)) begin
                if (base.n_expo) upd.n_valid = 1'b0;
                else             upd.n_expo  = 1'b1;
            end else if (s_text_byte == CH_PLUS) begin
                if (!base.n_expo) upd.n_valid = 1'b0;
                else              upd.n_expo  = 1'b0;
            end else if (s_text_byte == CH_MINUS) begin
                if (!pos_zero && !base.n_expo) upd.n_valid = 1'b0;
                else                           upd.n_expo  = 1'b0;
            end else if (s_text_byte == CH_DOT) begin
                if (base.n_dot || pos_zero) upd.n_valid = 1'b0;
                else                        upd.n_dot   = 1'b1;
            end else if (!is_digit) begin
                upd.n_valid = 1'b0;
            end
        end

        // Unescaped closing quote; two backslashes before it still close
        closes = upd.quote && !pos_zero && (s_text_byte == CH_QUOTE)
              && (!base.bs[0] || base.bs[1]);
        upd.bs = {base.bs[0], (s_text_byte == CH_BSLASH)};

        if (32'(pos) >= 32'(MAX_TOKEN_LEN)) begin
            upd.ovf = 1'b1;
        end else begin
            upd.len = pos + RUN_W'(1);
        end
        upd.pend = base.pend || upd.n_valid;

        // First complete literal in priority order
        lit_hit = 1'b0;
        hit_k   = LIT_TRUE;
        for (int k = 2; k >= 0; k--) begin
            if (upd.lit[k] && (32'(pos) + 32'd1 == 32'(lit_len(2'(k))))) begin
                lit_hit = 1'b1;
                hit_k   = 2'(k);
            end
        end
    end

    // Token selection and run update per request
    always_comb begin
        tok_a    = make_token(KIND_NUMBER, run_reg.len, run_reg.ovf);
        a_v      = 1'b0;
        tok_b    = make_token(KIND_END, '0, 1'b0);
        b_v      = 1'b0;
        run_next = run_reg;

        if (s_end_of_text) begin
            a_v      = run_reg.pend;
            b_v      = 1'b1;
            run_next = RUN_RESET;
        end else if (!in_str && is_struct) begin
            a_v   = run_reg.pend;
            tok_b = make_token(struct_kind, RUN_W'(1), 1'b0);
            b_v   = 1'b1;
            if (run_reg.pend) run_next = RUN_RESET;
        end else if (!in_str && is_ws) begin
            a_v = run_reg.pend;
            if (run_reg.pend) run_next = RUN_RESET;
        end else begin
            a_v = flushed;
            if (lit_hit) begin
                tok_b    = make_token(lit_kind(hit_k), upd.len, upd.ovf);
                b_v      = 1'b1;
                run_next = RUN_RESET;
            end else if (closes) begin
                tok_b    = make_token(KIND_STRING, upd.len, upd.ovf);
                b_v      = 1'b1;
                run_next = RUN_RESET;
            end else begin
                run_next = upd;
            end
        end

        // Pack into queue slots, marking the final token of this request
        if (a_v) begin
            slot0  = tok_a;
            slot1  = tok_b;
            n_push = b_v ? 2'd2 : 2'd1;
        end else begin
            slot0  = tok_b;
            slot1  = tok_b;
            n_push = b_v ? 2'd1 : 2'd0;
        end
        if (n_push == 2'd2) slot1.last = 1'b1;
        else                slot0.last = 1'b1;
    end

    // Queue pointers
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (pop) rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        if (acc) wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        cnt_next = cnt_reg + (acc ? CNT_W'(n_push) : '0) - CNT_W'(pop);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= RUN_RESET;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (acc) run_reg <= run_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (acc && (n_push != 2'd0)) fifo_mem[wr_ptr_reg] <= slot0;
        if (acc && (n_push == 2'd2)) fifo_mem[wr_ptr_reg + PTR_W'(1)] <= slot1;
    end

    `JBT_ASSERT_NEVER(a_cnt_bound, aclk, aresetn, cnt_reg > CNT_W'(DEPTH), "queue overfilled")
    `JBT_ASSERT_IMP(a_room_on_accept, aclk, aresetn, acc, cnt_reg <= CNT_W'(DEPTH - 2), "accepted without room for two tokens")
    `JBT_ASSERT_NXT(a_clear_after_end, aclk, aresetn, acc && s_end_of_text, (run_reg.len == '0) && !run_reg.pend && !run_reg.ovf, "run not cleared after end of text")
    `JBT_ASSERT_IMP(a_ovf_at_max, aclk, aresetn, run_reg.ovf, 32'(run_reg.len) == 32'(MAX_TOKEN_LEN), "overflow flag without saturated length")

endmodule

`default_nettype wire
